// ===== sv/fos_pkg.sv =====
package fos_pkg;

  localparam int PIXEL_BITS_DEF = 16;
  localparam int FIELD_BITS     = 16;
  localparam int SUM_BITS       = 32;
  localparam int NUM_COSTS      = 5;
  localparam int TAP_DEPTH      = 4;
  localparam int COL_BITS       = 5;

  typedef logic [COL_BITS-1:0] col_t;
  typedef logic [SUM_BITS-1:0] sum_t;

  localparam col_t ROW_W_NARROW = col_t'(8);
  localparam col_t ROW_W_WIDE   = col_t'(16);
  localparam col_t COL_MAX      = col_t'(19);

  typedef enum logic [1:0] {
    REG_WIDTH_SELECT = 2'd0,
    REG_FIVE_OFFSET  = 2'd1,
    REG_CENTRE_EN    = 2'd2,
    REG_SUB_SHIFT    = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic signed [FIELD_BITS-1:0] org_pixel;
    logic signed [FIELD_BITS-1:0] cur_pixel;
    logic                         last_in_block;
  } in_word_t;

  typedef struct packed {
    sum_t cost_zero;
    sum_t cost_one;
    sum_t cost_two;
    sum_t cost_three;
    sum_t cost_four;
    logic centre_valid;
  } out_word_t;

  typedef struct packed {
    logic       move;
    logic       clear;
    logic       halve;
    logic [1:0] shift;
  } acc_ctl_t;

endpackage

// ===== sv/fos_in_if.sv =====
interface fos_in_if import fos_pkg::*; ();
  logic     valid;
  logic     ready;
  in_word_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ===== sv/fos_out_if.sv =====
interface fos_out_if import fos_pkg::*; ();
  logic      valid;
  logic      ready;
  out_word_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ===== sv/fos_tap.sv =====
module fos_tap import fos_pkg::*; #(
  parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         shift_en,
  input  logic                         clear,
  input  logic signed [PIXEL_BITS-1:0] org_in,
  input  logic signed [PIXEL_BITS-1:0] cur_in,
  output logic signed [PIXEL_BITS-1:0] org_q,
  output logic signed [PIXEL_BITS-1:0] cur_q
);

  always_ff @(posedge clk) begin
    if (rst || (shift_en && clear)) begin
      org_q <= '0;
      cur_q <= '0;
    end else if (shift_en) begin
      org_q <= org_in;
      cur_q <= cur_in;
    end
  end

endmodule

// ===== sv/fos_acc.sv =====
module fos_acc import fos_pkg::*; #(
  parameter int DIFF_BITS = PIXEL_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  acc_ctl_t             ctl,
  input  logic                 add_en,
  input  logic [DIFF_BITS-1:0] diff,
  output sum_t                 total
);

  sum_t                sum;
  sum_t                sum_next;
  logic [SUM_BITS:0]   wide_sum;
  logic [SUM_BITS+2:0] scaled;
  logic [SUM_BITS+2:0] halved;

  always_comb begin
    wide_sum = {1'b0, sum} + (SUM_BITS+1)'(diff);
    if (!add_en) begin
      sum_next = sum;
    end else if (wide_sum[SUM_BITS]) begin
      sum_next = '1;
    end else begin
      sum_next = wide_sum[SUM_BITS-1:0];
    end
    scaled = {3'b000, sum_next} << ctl.shift;
    halved = ctl.halve ? (scaled >> 1) : scaled;
    total  = (|halved[SUM_BITS+2:SUM_BITS]) ? '1 : halved[SUM_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
    end else if (ctl.move) begin
      sum <= ctl.clear ? '0 : sum_next;
    end
  end

endmodule

// ===== sv/five_offset_sad_engine.sv =====
// Channel   Direction  Payload                                   Handshake
// pix       in         org_pixel, cur_pixel, last_in_block       valid / ready
// cost      out        cost_zero .. cost_four, centre_valid      valid / ready
// apb       in         width_select, five_offset_mode,           psel / penable
//                      centre_enable, sub_shift
//
// One word is taken per cycle unless a last word waits. The delay taps shift on every
// accepted word; the five cost cells add as it leaves the difference stage.
// Reset is synchronous and needs no further clearing time.
// A last word waits in the difference stage only while the previous result is still held.
module five_offset_sad_engine import fos_pkg::*; #(
  parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  fos_in_if.sink      pix,
  fos_out_if.source   cost,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic       width_select;
  logic       five_offset_mode;
  logic       centre_enable;
  logic [1:0] sub_shift;
  logic       cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_select     <= 1'b1;
      five_offset_mode <= 1'b1;
      centre_enable    <= 1'b1;
      sub_shift        <= 2'd0;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(paddr[3:2]))
        REG_WIDTH_SELECT: width_select     <= pwdata[0];
        REG_FIVE_OFFSET:  five_offset_mode <= pwdata[0];
        REG_CENTRE_EN:    centre_enable    <= pwdata[0];
        REG_SUB_SHIFT:    sub_shift        <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_reg_t'(paddr[3:2]))
      REG_WIDTH_SELECT: prdata = {31'd0, width_select};
      REG_FIVE_OFFSET:  prdata = {31'd0, five_offset_mode};
      REG_CENTRE_EN:    prdata = {31'd0, centre_enable};
      REG_SUB_SHIFT:    prdata = {30'd0, sub_shift};
      default:          prdata = '0;
    endcase
  end

  logic pix_take;
  logic a_valid;
  logic a_last;
  logic a_move;
  logic a_mode;
  logic a_centre;
  logic [1:0] a_shift;
  logic [NUM_COSTS-1:0] a_en;
  logic [PIXEL_BITS-1:0] a_diff [NUM_COSTS];
  logic out_valid;
  out_word_t out_data;

  assign pix_take  = pix.valid && pix.ready;
  assign a_move    = a_valid && (!a_last || !out_valid || cost.ready);
  assign pix.ready = !a_valid || a_move;

  logic signed [PIXEL_BITS-1:0] org_s;
  logic signed [PIXEL_BITS-1:0] cur_s;
  logic signed [PIXEL_BITS-1:0] tap_org [TAP_DEPTH];
  logic signed [PIXEL_BITS-1:0] tap_cur [TAP_DEPTH];

  assign org_s = pix.data.org_pixel[PIXEL_BITS-1:0];
  assign cur_s = pix.data.cur_pixel[PIXEL_BITS-1:0];

  for (genvar i = 0; i < TAP_DEPTH; i++) begin : g_tap
    if (i == 0) begin : g_head
      fos_tap #(.PIXEL_BITS(PIXEL_BITS)) u_tap (
        .clk(clk), .rst(rst), .shift_en(pix_take), .clear(pix.data.last_in_block),
        .org_in(org_s), .cur_in(cur_s), .org_q(tap_org[i]), .cur_q(tap_cur[i])
      );
    end else begin : g_body
      fos_tap #(.PIXEL_BITS(PIXEL_BITS)) u_tap (
        .clk(clk), .rst(rst), .shift_en(pix_take), .clear(pix.data.last_in_block),
        .org_in(tap_org[i-1]), .cur_in(tap_cur[i-1]),
        .org_q(tap_org[i]), .cur_q(tap_cur[i])
      );
    end
  end

  col_t col_count;
  col_t col_count_next;
  col_t row_w;
  col_t row_end;
  logic [NUM_COSTS-1:0] en_next;
  logic signed [PIXEL_BITS-1:0] op_a [NUM_COSTS];
  logic signed [PIXEL_BITS-1:0] op_b [NUM_COSTS];
  logic signed [PIXEL_BITS:0] delta [NUM_COSTS];
  logic [PIXEL_BITS-1:0] diff_next [NUM_COSTS];

  always_comb begin
    row_w   = width_select ? ROW_W_WIDE : ROW_W_NARROW;
    en_next = '0;
    if (five_offset_mode) begin
      row_end    = row_w + col_t'(3);
      en_next[0] = (col_count >= col_t'(4)) && (col_count <= row_w + col_t'(3));
      en_next[4] = en_next[0];
      en_next[1] = (col_count >= col_t'(3)) && (col_count <= row_w + col_t'(2));
      en_next[3] = en_next[1];
      en_next[2] = centre_enable && (col_count >= col_t'(2))
                   && (col_count <= row_w + col_t'(1));
    end else begin
      row_end    = row_w - col_t'(1);
      en_next[0] = (col_count <= row_w - col_t'(1));
    end
    col_count_next = (col_count >= row_end) ? '0 : col_count + col_t'(1);

    op_a[0] = five_offset_mode ? tap_org[3] : org_s;
    op_b[0] = cur_s;
    op_a[1] = tap_org[1];
    op_b[1] = cur_s;
    op_a[2] = org_s;
    op_b[2] = cur_s;
    op_a[3] = org_s;
    op_b[3] = tap_cur[1];
    op_a[4] = org_s;
    op_b[4] = tap_cur[3];
    for (int k = 0; k < NUM_COSTS; k++) begin
      delta[k]     = {op_a[k][PIXEL_BITS-1], op_a[k]} - {op_b[k][PIXEL_BITS-1], op_b[k]};
      diff_next[k] = delta[k][PIXEL_BITS] ? PIXEL_BITS'(-delta[k])
                                          : delta[k][PIXEL_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
    end else if (pix_take) begin
      col_count <= pix.data.last_in_block ? '0 : col_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (pix.ready) begin
      a_valid <= pix.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_take) begin
      a_last   <= pix.data.last_in_block;
      a_en     <= en_next;
      a_mode   <= five_offset_mode;
      a_centre <= centre_enable;
      a_shift  <= sub_shift;
      a_diff   <= diff_next;
    end
  end

  acc_ctl_t acc_ctl;
  sum_t     total [NUM_COSTS];

  assign acc_ctl = '{move: a_move, clear: a_last, halve: a_mode, shift: a_shift};

  for (genvar k = 0; k < NUM_COSTS; k++) begin : g_acc
    fos_acc #(.DIFF_BITS(PIXEL_BITS)) u_acc (
      .clk(clk), .rst(rst), .ctl(acc_ctl), .add_en(a_en[k]),
      .diff(a_diff[k]), .total(total[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (a_move && a_last) begin
      out_valid <= 1'b1;
    end else if (cost.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_move && a_last) begin
      out_data.cost_zero    <= total[0];
      out_data.cost_one     <= a_mode ? total[1] : '0;
      out_data.cost_two     <= (a_mode && a_centre) ? total[2] : '0;
      out_data.cost_three   <= a_mode ? total[3] : '0;
      out_data.cost_four    <= a_mode ? total[4] : '0;
      out_data.centre_valid <= a_mode && a_centre;
    end
  end

  assign cost.valid = out_valid;
  assign cost.data  = out_data;

  a_last_waits: assert property (@(posedge clk) disable iff (rst)
    a_valid && a_last && out_valid && !cost.ready |=> a_valid && a_last)
    else $error("last word left the difference stage while the result was held");

  result_follows_last: assert property (@(posedge clk) disable iff (rst)
    a_move && a_last |=> out_valid)
    else $error("no result after a last word");

  column_restart: assert property (@(posedge clk) disable iff (rst)
    pix_take && pix.data.last_in_block |=> col_count == '0)
    else $error("column count not cleared at block end");

  column_bound: assert property (@(posedge clk) disable iff (rst)
    col_count <= COL_MAX)
    else $error("column count out of range");

  centre_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.centre_valid |-> out_data.cost_two == '0)
    else $error("centre cost set while not valid");

endmodule
